// ===== rtl/core/kcr_pkg.sv =====
package kcr_pkg;

    localparam int SAMPLE_FRAC_BITS   = 16;
    localparam int EXPONENT_FRAC_BITS = 8;
    localparam int LOG_FB             = 30;
    localparam int ROOT_COUNT         = 31;
    localparam int EXP_RESET          = 256;

    localparam logic [0:0] REG_EXPONENT_A = 1'b0;
    localparam logic [0:0] REG_EXPONENT_B = 1'b1;

    function automatic logic [63:0] f_isqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        rem   = n;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // entry i holds 2^(-2^-i) in q0.32
    function automatic logic [ROOT_COUNT-1:0][31:0] f_roots();
        logic [ROOT_COUNT-1:0][31:0] r;
        logic [63:0]                 s;
        r    = '0;
        r[0] = 32'h8000_0000;
        for (int i = 1; i < ROOT_COUNT; i++) begin
            s    = f_isqrt({r[i-1], 32'h0});
            r[i] = s[31:0];
        end
        return r;
    endfunction

    localparam logic [ROOT_COUNT-1:0][31:0] ROOT_ROM = f_roots();

endpackage

// ===== rtl/core/kcr_power.sv =====
module kcr_power import kcr_pkg::*; #(
    parameter int IN_W   = 16,
    parameter int FB     = 16,
    parameter int EXP_W  = 16,
    parameter int EXP_FB = 8,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_x,
    input  logic [EXP_W-1:0]  i_e,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [32:0]       o_y,
    output logic [SIDE_W-1:0] o_side
);

    localparam int LZ_W   = 6;
    localparam int LOG_W  = LOG_FB + LZ_W;
    localparam int PROD_W = LOG_W + EXP_W;
    localparam int K_W    = PROD_W - EXP_FB - LOG_FB;
    localparam int M_W    = LOG_FB + 1;
    localparam int SH_W   = IN_W + LOG_FB;
    localparam int NSTEP  = LOG_FB;

    // leading one
    logic              r_a_valid;
    logic [IN_W-1:0]   r_a_x;
    logic [LZ_W-1:0]   r_a_msb;
    logic [SIDE_W-1:0] r_a_side;
    logic [LZ_W-1:0]   n_a_msb;

    always_comb begin
        n_a_msb = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (i_x[i]) n_a_msb = LZ_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= i_x;
            r_a_msb  <= n_a_msb;
            r_a_side <= i_side;
        end
    end

    // normalize and square
    logic              r_sq_valid [0:NSTEP];
    logic [M_W-1:0]    r_sq_m     [0:NSTEP];
    logic [LOG_FB-1:0] r_sq_frac  [0:NSTEP];
    logic [LZ_W-1:0]   r_sq_lz    [0:NSTEP];
    logic [SIDE_W-1:0] r_sq_side  [0:NSTEP];
    logic [SH_W-1:0]   n_b_shift;

    assign n_b_shift = (SH_W'(r_a_x) << LOG_FB) >> r_a_msb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_valid[0] <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_m[0]    <= n_b_shift[M_W-1:0];
            r_sq_frac[0] <= '0;
            r_sq_lz[0]   <= LZ_W'(FB) - r_a_msb;
            r_sq_side[0] <= r_a_side;
        end
    end

    for (genvar g = 1; g <= NSTEP; g++) begin : g_sq
        logic [2*M_W-1:0]  n_sq;
        logic [M_W:0]      n_top;
        logic [M_W-1:0]    n_m;
        logic [LOG_FB-1:0] n_frac;

        assign n_sq  = (2*M_W)'(r_sq_m[g-1]) * (2*M_W)'(r_sq_m[g-1]);
        assign n_top = n_sq[2*M_W-1:LOG_FB];

        always_comb begin
            if (n_top[M_W]) begin
                n_m    = n_top[M_W:1];
                n_frac = r_sq_frac[g-1] | (LOG_FB'(1) << (LOG_FB - g));
            end else begin
                n_m    = n_top[M_W-1:0];
                n_frac = r_sq_frac[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_sq_valid[g] <= r_sq_valid[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_m[g]    <= n_m;
                r_sq_frac[g] <= n_frac;
                r_sq_lz[g]   <= r_sq_lz[g-1];
                r_sq_side[g] <= r_sq_side[g-1];
            end
        end
    end

    // log value
    logic              r_c_valid;
    logic [LOG_W-1:0]  r_c_log;
    logic [SIDE_W-1:0] r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_sq_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_log  <= {r_sq_lz[NSTEP], LOG_FB'(0)} - LOG_W'(r_sq_frac[NSTEP]);
            r_c_side <= r_sq_side[NSTEP];
        end
    end

    // scale by exponent
    logic [PROD_W-1:0] n_d_prod;
    logic [K_W-1:0]    n_d_k;

    assign n_d_prod = PROD_W'(r_c_log) * PROD_W'(i_e);
    assign n_d_k    = n_d_prod[PROD_W-1:EXP_FB+LOG_FB];

    logic              r_ex_valid [0:NSTEP];
    logic [32:0]       r_ex_r     [0:NSTEP];
    logic [LOG_FB-1:0] r_ex_low   [0:NSTEP];
    logic [LZ_W-1:0]   r_ex_k     [0:NSTEP];
    logic              r_ex_zero  [0:NSTEP];
    logic [SIDE_W-1:0] r_ex_side  [0:NSTEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_ex_valid[0] <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ex_r[0]    <= 33'h1_0000_0000;
            r_ex_low[0]  <= n_d_prod[EXP_FB+LOG_FB-1:EXP_FB];
            r_ex_k[0]    <= n_d_k[LZ_W-1:0];
            r_ex_zero[0] <= (n_d_k >= K_W'(33));
            r_ex_side[0] <= r_c_side;
        end
    end

    for (genvar g = 1; g <= NSTEP; g++) begin : g_ex
        logic [64:0] n_prod;
        logic [32:0] n_r;

        assign n_prod = 65'(r_ex_r[g-1]) * 65'(ROOT_ROM[g]) + (65'(1) << 31);
        assign n_r    = r_ex_low[g-1][LOG_FB-g] ? n_prod[64:32] : r_ex_r[g-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ex_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_ex_valid[g] <= r_ex_valid[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ex_r[g]    <= n_r;
                r_ex_low[g]  <= r_ex_low[g-1];
                r_ex_k[g]    <= r_ex_k[g-1];
                r_ex_zero[g] <= r_ex_zero[g-1];
                r_ex_side[g] <= r_ex_side[g-1];
            end
        end
    end

    // integer part shift
    logic              r_e_valid;
    logic [32:0]       r_e_y;
    logic [SIDE_W-1:0] r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= r_ex_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_y    <= r_ex_zero[NSTEP] ? 33'h0 : (r_ex_r[NSTEP] >> r_ex_k[NSTEP]);
            r_e_side <= r_ex_side[NSTEP];
        end
    end

    assign o_valid = r_e_valid;
    assign o_y     = r_e_y;
    assign o_side  = r_e_side;

endmodule

// ===== rtl/core/kumaraswamy_curve_remap.sv =====
// an accepted request passes the input register, both power units, the rounding, blend and output registers to o_valid
// throughput: one request per cycle while the output is not stalled, set by the fully pipelined log and exp chains
//   (at most one multiplier per stage, two power units of 65 stages each)
// a stall at a valid output freezes the whole pipeline; nothing is dropped or repeated
// reset: synchronous active low, clears all valid bits and sets both exponents to 1.0
module kumaraswamy_curve_remap import kcr_pkg::*; #(
    parameter int SAMPLE_FRAC_BITS   = kcr_pkg::SAMPLE_FRAC_BITS,
    parameter int EXPONENT_FRAC_BITS = kcr_pkg::EXPONENT_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [SAMPLE_FRAC_BITS:0]       i_sample_value,
    input  logic [SAMPLE_FRAC_BITS:0]       i_mask_weight,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [SAMPLE_FRAC_BITS:0]       o_remapped_value,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_index,
    input  logic [EXPONENT_FRAC_BITS+7:0]   i_cfg_data
);

    localparam int S_W    = SAMPLE_FRAC_BITS + 1;
    localparam int EXP_W  = EXPONENT_FRAC_BITS + 8;
    localparam int SIDE_W = 2 * S_W + 2;
    localparam int FR_W   = 34 + SAMPLE_FRAC_BITS;
    localparam int FQ_W   = FR_W - 32;
    localparam int PB_W   = 2 * S_W;
    localparam int SUM_W  = PB_W + 1;
    localparam int RS_W   = SUM_W - SAMPLE_FRAC_BITS;
    localparam logic [S_W-1:0] ONE_S = S_W'(1) << SAMPLE_FRAC_BITS;

    logic [EXP_W-1:0] r_exponent_a;
    logic [EXP_W-1:0] r_exponent_b;
    logic [EXP_W-1:0] n_a_eff;
    logic [EXP_W-1:0] n_b_eff;
    logic             n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent_a <= EXP_W'(EXP_RESET);
            r_exponent_b <= EXP_W'(EXP_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_EXPONENT_A: r_exponent_a <= i_cfg_data;
                REG_EXPONENT_B: r_exponent_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero exponent acts as one lsb
    assign n_a_eff = (r_exponent_a == '0) ? EXP_W'(1) : r_exponent_a;
    assign n_b_eff = (r_exponent_b == '0) ? EXP_W'(1) : r_exponent_b;

    logic r_out_valid;
    assign n_en    = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    // input saturation
    logic           r_t1_valid;
    logic [S_W-1:0] r_t1_v;
    logic [S_W-1:0] r_t1_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
        end else if (n_en) begin
            r_t1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_t1_v <= (i_sample_value > ONE_S) ? ONE_S : i_sample_value;
            r_t1_m <= (i_mask_weight > ONE_S) ? ONE_S : i_mask_weight;
        end
    end

    logic              n_vz;
    logic              n_vone;
    logic [SIDE_W-1:0] n_side1;

    assign n_vz    = (r_t1_v == '0);
    assign n_vone  = (r_t1_v >= ONE_S);
    assign n_side1 = {r_t1_v, r_t1_m, n_vz, n_vone};

    // inner power v^a
    logic              n_p1_valid;
    logic [32:0]       n_p;
    logic [SIDE_W-1:0] n_p1_side;

    kcr_power #(
        .IN_W   (SAMPLE_FRAC_BITS),
        .FB     (SAMPLE_FRAC_BITS),
        .EXP_W  (EXP_W),
        .EXP_FB (EXPONENT_FRAC_BITS),
        .SIDE_W (SIDE_W)
    ) u_pow_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (r_t1_valid),
        .i_x     (r_t1_v[SAMPLE_FRAC_BITS-1:0]),
        .i_e     (n_a_eff),
        .i_side  (n_side1),
        .o_valid (n_p1_valid),
        .o_y     (n_p),
        .o_side  (n_p1_side)
    );

    logic              n_p_vz;
    logic              n_p_vone;
    logic              n_f_one;
    logic              n_f_zero;
    logic [32:0]       n_w;
    logic [SIDE_W-1:0] n_side2;

    assign n_p_vz   = n_p1_side[1];
    assign n_p_vone = n_p1_side[0];
    assign n_w      = 33'h1_0000_0000 - n_p;
    assign n_f_one  = n_p_vone || (!n_p_vz && n_p[32]);
    assign n_f_zero = !n_p_vone && (n_p_vz || (!n_p[32] && n_p == '0));
    assign n_side2  = {n_p1_side[SIDE_W-1:2], n_f_one, n_f_zero};

    // outer power (1 - v^a)^b
    logic              n_p2_valid;
    logic [32:0]       n_q;
    logic [SIDE_W-1:0] n_p2_side;

    kcr_power #(
        .IN_W   (32),
        .FB     (32),
        .EXP_W  (EXP_W),
        .EXP_FB (EXPONENT_FRAC_BITS),
        .SIDE_W (SIDE_W)
    ) u_pow_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (n_p1_valid),
        .i_x     (n_w[31:0]),
        .i_e     (n_b_eff),
        .i_side  (n_side2),
        .o_valid (n_p2_valid),
        .o_y     (n_q),
        .o_side  (n_p2_side)
    );

    // curve value rounding
    logic [32:0]     n_f32;
    logic [FR_W-1:0] n_fr;
    logic [FQ_W-1:0] n_fq;
    logic [S_W-1:0]  n_f;

    assign n_f32 = 33'h1_0000_0000 - n_q;
    assign n_fr  = ({1'b0, n_f32, SAMPLE_FRAC_BITS'(0)}) + (FR_W'(1) << 31);
    assign n_fq  = n_fr[FR_W-1:32];

    always_comb begin
        if (n_p2_side[1]) begin
            n_f = ONE_S;
        end else if (n_p2_side[0]) begin
            n_f = '0;
        end else if (n_fq > FQ_W'(ONE_S)) begin
            n_f = ONE_S;
        end else begin
            n_f = n_fq[S_W-1:0];
        end
    end

    logic           r_t3_valid;
    logic [S_W-1:0] r_t3_v;
    logic [S_W-1:0] r_t3_m;
    logic [S_W-1:0] r_t3_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3_valid <= 1'b0;
        end else if (n_en) begin
            r_t3_valid <= n_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_t3_v <= n_p2_side[SIDE_W-1:S_W+2];
            r_t3_m <= n_p2_side[S_W+1:2];
            r_t3_f <= n_f;
        end
    end

    // blend products
    logic            r_t4_valid;
    logic [PB_W-1:0] r_t4_pv;
    logic [PB_W-1:0] r_t4_pf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t4_valid <= 1'b0;
        end else if (n_en) begin
            r_t4_valid <= r_t3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_t4_pv <= PB_W'(ONE_S - r_t3_m) * PB_W'(r_t3_v);
            r_t4_pf <= PB_W'(r_t3_m) * PB_W'(r_t3_f);
        end
    end

    // blend sum and output register
    logic [SUM_W-1:0] n_sum;
    logic [RS_W-1:0]  n_rs;
    logic [S_W-1:0]   r_out_value;

    assign n_sum = SUM_W'(r_t4_pv) + SUM_W'(r_t4_pf) + SUM_W'(ONE_S >> 1);
    assign n_rs  = n_sum[SUM_W-1:SAMPLE_FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_en) begin
            r_out_valid <= r_t4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out_value <= (n_rs > RS_W'(ONE_S)) ? ONE_S : n_rs[S_W-1:0];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_remapped_value = r_out_value;

endmodule

// ===== rtl/core/kcr_checker.sv =====
module kcr_checker import kcr_pkg::*; #(
    parameter int SAMPLE_FRAC_BITS = kcr_pkg::SAMPLE_FRAC_BITS
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [SAMPLE_FRAC_BITS:0] o_remapped_value
);

    localparam logic [SAMPLE_FRAC_BITS:0] ONE_S =
        (SAMPLE_FRAC_BITS + 1)'(1) << SAMPLE_FRAC_BITS;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_remapped_value))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_remapped_value <= ONE_S)
        else $error("result above one");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind kumaraswamy_curve_remap kcr_checker #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
) u_kcr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_remapped_value (o_remapped_value)
);
